/* design/hcbd_pkg.sv */
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants for the processor port and bank decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbd_pkg;

    // decoded target of one bus access
    typedef enum logic [3:0] {
        RG_RAM     = 4'd0,
        RG_VBANK   = 4'd1,
        RG_VB39    = 4'd2,
        RG_VB3F    = 4'd3,
        RG_BASIC   = 4'd4,
        RG_KERNAL  = 4'd5,
        RG_CHARGEN = 4'd6,
        RG_VIC     = 4'd7,
        RG_SID     = 4'd8,
        RG_COLOUR  = 4'd9,
        RG_CIA1    = 4'd10,
        RG_CIA2    = 4'd11,
        RG_EXP     = 4'd12,
        RG_IFACE   = 4'd13,
        RG_OPEN    = 4'd14,
        RG_PORT    = 4'd15
    } t_region;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_EXPANSION = 1'b0,
        CFG_INTERFACE = 1'b1
    } t_cfg_index;

    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;

    localparam logic [7:0]  PORT_DIR_RESET = 8'h00;
    localparam logic [7:0]  PORT_OUT_RESET = 8'hff;
    localparam logic [7:0]  PORT_MASK      = 8'h3f;
    localparam logic [7:0]  PORT_MASK_TAPE = 8'h2f;
    localparam logic [15:0] DMA_ADDR       = 16'hff00;
    localparam logic [5:0]  SUB_PAGE_39    = 6'h39;
    localparam logic [5:0]  SUB_PAGE_3F    = 6'h3f;

    typedef struct packed {
        logic        req_type;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [1:0]  video_bank;
        logic        tape_button;
    } t_in_item;

    typedef struct packed {
        t_region     target_region;
        logic [15:0] target_offset;
        logic [7:0]  port_read_data;
        logic        dma_trigger;
        logic [2:0]  bank_mode;
    } t_out_item;

    typedef struct packed {
        logic expansion_enable;
        logic interface_enable;
    } t_cfg;

endpackage

`default_nettype wire

/* design/hcbd_cfg.sv */
// ----------------------------------------------------------------------------
// hcbd_cfg
// Configuration registers behind an APB-style slave port.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [hcbd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [hcbd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [hcbd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready,
    output hcbd_pkg::t_cfg                         o_cfg
);
    import hcbd_pkg::*;

    logic       r_expansion_enable;
    logic       r_interface_enable;
    logic       w_write;
    t_cfg_index w_index;

    assign pready  = 1'b1;
    assign w_write = psel && penable && pwrite;
    assign w_index = t_cfg_index'(paddr[2]);

    // register writes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expansion_enable <= 1'b0;
            r_interface_enable <= 1'b0;
        end else if (w_write) begin
            unique case (w_index)
                CFG_EXPANSION: r_expansion_enable <= pwdata[0];
                CFG_INTERFACE: r_interface_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        unique case (w_index)
            CFG_EXPANSION: prdata[0] = r_expansion_enable;
            CFG_INTERFACE: prdata[0] = r_interface_enable;
            default: ;
        endcase
    end

    assign o_cfg.expansion_enable = r_expansion_enable;
    assign o_cfg.interface_enable = r_interface_enable;

endmodule

`default_nettype wire

/* design/hcbd_core.sv */
// ----------------------------------------------------------------------------
// hcbd_core
// Processor port registers and single-pass address decode of one access.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_core (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire hcbd_pkg::t_in_item  i_item,
    input  wire hcbd_pkg::t_cfg      i_cfg,
    output hcbd_pkg::t_out_item      o_result
);
    import hcbd_pkg::*;

    logic [7:0]  r_dir;
    logic [7:0]  r_out;
    logic [7:0]  n_dir;
    logic [7:0]  n_out;
    logic [7:0]  w_page;
    logic [2:0]  w_mode;
    logic        w_is_port;
    logic        w_io_page;
    logic        w_io_mode;
    t_region     w_io_rg;
    logic [15:0] w_io_off;
    t_region     w_rg;
    logic [15:0] w_off;
    logic [7:0]  w_prd;
    logic        w_dma;

    assign w_page    = i_item.address[15:8];
    assign w_mode    = 3'(~r_dir | r_out);
    assign w_is_port = (i_item.address[15:1] == 15'd0);
    assign w_io_page = (w_page[7:4] == 4'hd);
    assign w_io_mode = (w_mode >= 3'd5);

    // port register update on a port write
    always_comb begin
        n_dir = r_dir;
        n_out = r_out;
        if (i_accept && w_is_port && i_item.req_type) begin
            if (i_item.address[0]) n_out = i_item.write_data;
            else                   n_dir = i_item.write_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir <= PORT_DIR_RESET;
            r_out <= PORT_OUT_RESET;
        end else begin
            r_dir <= n_dir;
            r_out <= n_out;
        end
    end

    // i/o space decode for pages d0..df
    always_comb begin
        w_io_rg  = RG_OPEN;
        w_io_off = {8'd0, i_item.address[7:0]};
        unique case (w_page[3:0]) inside
            [4'h0:4'h3]: begin
                w_io_rg  = RG_VIC;
                w_io_off = {6'd0, i_item.address[9:0]};
            end
            [4'h4:4'h7]: begin
                w_io_rg  = RG_SID;
                w_io_off = {6'd0, i_item.address[9:0]};
            end
            [4'h8:4'hb]: begin
                w_io_rg  = RG_COLOUR;
                w_io_off = {6'd0, i_item.address[9:0]};
            end
            4'hc: w_io_rg = RG_CIA1;
            4'hd: w_io_rg = RG_CIA2;
            4'hf: begin
                if (i_cfg.expansion_enable) begin
                    w_io_rg  = RG_EXP;
                    w_io_off = {12'd0, i_item.address[3:0]};
                end else if (i_cfg.interface_enable) begin
                    w_io_rg  = RG_IFACE;
                    w_io_off = {13'd0, i_item.address[2:0]};
                end
            end
            default: ;
        endcase
    end

    // region select for reads and writes
    always_comb begin
        w_rg  = RG_RAM;
        w_off = i_item.address;
        w_prd = 8'd0;
        w_dma = 1'b0;
        if (w_is_port) begin
            w_rg = RG_PORT;
            if (!i_item.req_type) begin
                if (i_item.address[0]) begin
                    w_prd = (r_out | ~r_dir)
                          & (i_item.tape_button ? PORT_MASK_TAPE : PORT_MASK);
                end else begin
                    w_prd = r_dir;
                end
            end
        end else if (i_item.req_type) begin
            if (w_io_page && w_io_mode) begin
                w_rg  = w_io_rg;
                w_off = w_io_off;
            end else if (w_page == 8'h00 || w_page == 8'hff) begin
                w_dma = (i_item.address == DMA_ADDR) && i_cfg.expansion_enable;
            end else if (w_page[7:6] == i_item.video_bank) begin
                if (w_page[5:0] == SUB_PAGE_39)      w_rg = RG_VB39;
                else if (w_page[5:0] == SUB_PAGE_3F) w_rg = RG_VB3F;
                else                                 w_rg = RG_VBANK;
            end
        end else begin
            if (w_page[7:5] == 3'b101 && w_mode[1:0] == 2'b11) begin
                w_rg  = RG_BASIC;
                w_off = {3'd0, i_item.address[12:0]};
            end else if (w_io_page && !w_mode[2] && w_mode[1:0] != 2'b00) begin
                w_rg  = RG_CHARGEN;
                w_off = {4'd0, i_item.address[11:0]};
            end else if (w_io_page && w_io_mode) begin
                w_rg  = w_io_rg;
                w_off = w_io_off;
            end else if (w_page[7:5] == 3'b111 && w_mode[1]) begin
                w_rg  = RG_KERNAL;
                w_off = {3'd0, i_item.address[12:0]};
            end
        end
    end

    assign o_result.target_region  = w_rg;
    assign o_result.target_offset  = w_off;
    assign o_result.port_read_data = w_prd;
    assign o_result.dma_trigger    = w_dma;
    assign o_result.bank_mode      = 3'(~n_dir | n_out);

endmodule

`default_nettype wire

/* design/hcbd_out_buf.sv */
// ----------------------------------------------------------------------------
// hcbd_out_buf
// Two-entry result buffer that decouples input accept from output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_out_buf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire hcbd_pkg::t_out_item  i_data,
    output logic                      o_full,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output hcbd_pkg::t_out_item       o_data
);
    import hcbd_pkg::*;

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_out_item  r_head;
    t_out_item  r_tail;
    logic       w_pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_head;
    assign w_pop   = o_valid && !i_stall;

    // occupancy
    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop)      n_count = r_count + 2'd1;
        else if (!i_push && w_pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 2'd0;
        else          r_count <= n_count;
    end

    // entry movement, head only changes on pop or when empty
    always_ff @(posedge i_clk) begin
        if (i_push && !w_pop) begin
            if (r_count == 2'd0) r_head <= i_data;
            else                 r_tail <= i_data;
        end else if (i_push && w_pop) begin
            if (r_count == 2'd1) r_head <= i_data;
            else begin
                r_head <= r_tail;
                r_tail <= i_data;
            end
        end else if (w_pop) begin
            r_head <= r_tail;
        end
    end

endmodule

`default_nettype wire

/* design/home_computer_bank_decoder.sv */
// ----------------------------------------------------------------------------
// home_computer_bank_decoder
// Processor port and bank switching decode for one CPU bus access per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_in_valid / o_in_stall / i_in_item carries one bus access
//   per item. Output channel o_out_valid / i_out_stall / o_out_item returns
//   the decoded region, offset, port read data, dma trigger and bank mode.
//   A result shows right after its accepting edge if no older result waits.
//   Throughput is one item per cycle while the buffer is not full; the
//   decode is a single pass of logic over the port registers and the item.
//   A two-entry result buffer sits at the output, so an item is still taken
//   while one result waits; o_in_stall rises only when both entries are full.
//   While the receiver stalls, the head result holds steady.
//   Port writes to addresses 0 and 1 update the port registers at accept.
//   Synchronous reset clears the buffer, sets the port direction to 0x00,
//   the port output to 0xff and both enables to 0.
//   The APB port (registers at byte 0 and 4) is written with no wait states.
// ----------------------------------------------------------------------------
`default_nettype none

module home_computer_bank_decoder (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire hcbd_pkg::t_in_item                i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output hcbd_pkg::t_out_item                    o_out_item,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [hcbd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [hcbd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [hcbd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);
    import hcbd_pkg::*;

    t_cfg      w_cfg;
    t_out_item w_result;
    logic      w_accept;
    logic      w_full;

    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid && !w_full;

    // configuration registers
    hcbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // port registers and decode
    hcbd_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    // result buffer
    hcbd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (o_out_item)
    );

endmodule

`default_nettype wire

/* design/hcbd_checker.sv */
// ----------------------------------------------------------------------------
// hcbd_port_checks
// Port-level checks of the bank decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_port_checks (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire hcbd_pkg::t_out_item o_out_item
);
    // buffer is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    // an accepted item always leaves a result valid in the cycle after
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted item produced no result");

    // input stalls only while results are waiting
    a_stall_backed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");

endmodule

bind home_computer_bank_decoder hcbd_port_checks u_hcbd_port_checks (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

/* tb/hcbd_checker.sv */
// ----------------------------------------------------------------------------
// hcbd_checker
// Watches the bus-access and decode channels of the bank decoder, keeps its
// own copy of the processor port and the enables, predicts every decode and
// compares each returned item field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbd_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_stall,
    input  wire hcbd_pkg::t_in_item                i_in_item,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_stall,
    input  wire hcbd_pkg::t_out_item               i_out_item,
    input  wire logic                              i_psel,
    input  wire logic                              i_penable,
    input  wire logic                              i_pwrite,
    input  wire logic [hcbd_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  wire logic [hcbd_pkg::APB_DATA_W-1:0]   i_pwdata,
    input  wire logic                              i_pready,
    output int                                     o_mismatches,
    output int                                     o_pending,
    output int                                     o_checked
);
    import hcbd_pkg::*;

    // shadow of the processor port and the page-DF enables
    logic [7:0] port_dir;
    logic [7:0] port_out;
    logic       exp_en;
    logic       iface_en;

    // decodes still owed by the block, oldest first
    t_out_item  expected_decodes[$];
    t_out_item  want;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
        port_dir     = PORT_DIR_RESET;
        port_out     = PORT_OUT_RESET;
        exp_en       = 1'b0;
        iface_en     = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        $display("mismatch on %s: got %h, predicted %h (result %0d)",
                 what, got, exp_val, o_checked);
        o_mismatches++;
    endtask

    // pages d0..df while i/o is banked in
    function automatic void io_select(input logic [15:0] addr, output t_region rg,
                                      output logic [15:0] off);
        logic [7:0] page;
        page = addr[15:8];
        if (page <= 8'hd3) begin
            rg = RG_VIC; off = addr & 16'h03ff;
        end else if (page <= 8'hd7) begin
            rg = RG_SID; off = addr & 16'h03ff;
        end else if (page <= 8'hdb) begin
            rg = RG_COLOUR; off = addr & 16'h03ff;
        end else if (page == 8'hdc) begin
            rg = RG_CIA1; off = addr & 16'h00ff;
        end else if (page == 8'hdd) begin
            rg = RG_CIA2; off = addr & 16'h00ff;
        end else if (page == 8'hdf && exp_en) begin
            rg = RG_EXP; off = addr & 16'h000f;
        end else if (page == 8'hdf && iface_en) begin
            rg = RG_IFACE; off = addr & 16'h0007;
        end else begin
            rg = RG_OPEN; off = addr & 16'h00ff;
        end
    endfunction

    // decode one bus access and apply any port write to the shadow
    function automatic t_out_item decode_access(input t_in_item acc);
        t_out_item  r;
        logic [7:0] page;
        logic [2:0] mode;
        t_region    rg;
        logic [15:0] off;
        page             = acc.address[15:8];
        mode             = ~port_dir[2:0] | port_out[2:0];
        rg               = RG_RAM;
        off              = acc.address;
        r.port_read_data = 8'h00;
        r.dma_trigger    = 1'b0;
        if (acc.address <= 16'h0001) begin
            rg = RG_PORT;
            if (acc.req_type) begin
                if (acc.address[0]) port_out = acc.write_data;
                else port_dir = acc.write_data;
            end else if (!acc.address[0]) begin
                r.port_read_data = port_dir;
            end else begin
                r.port_read_data = (port_out | ~port_dir)
                                   & (acc.tape_button ? PORT_MASK_TAPE : PORT_MASK);
            end
        end else if (acc.req_type) begin
            if (page[7:4] == 4'hd && mode >= 3'd5) begin
                io_select(acc.address, rg, off);
            end else if (page == 8'h00 || page == 8'hff) begin
                if (acc.address == DMA_ADDR && exp_en) r.dma_trigger = 1'b1;
            end else if (page[7:6] == acc.video_bank) begin
                if (page[5:0] == SUB_PAGE_39) rg = RG_VB39;
                else if (page[5:0] == SUB_PAGE_3F) rg = RG_VB3F;
                else rg = RG_VBANK;
            end
        end else begin
            if (page[7:5] == 3'b101 && (mode == 3'd3 || mode == 3'd7)) begin
                rg = RG_BASIC; off = acc.address & 16'h1fff;
            end else if (page[7:4] == 4'hd && mode >= 3'd1 && mode <= 3'd3) begin
                rg = RG_CHARGEN; off = acc.address & 16'h0fff;
            end else if (page[7:4] == 4'hd && mode >= 3'd5) begin
                io_select(acc.address, rg, off);
            end else if (page[7:5] == 3'b111 && mode[1]) begin
                rg = RG_KERNAL; off = acc.address & 16'h1fff;
            end
        end
        r.target_region = rg;
        r.target_offset = off;
        r.bank_mode     = ~port_dir[2:0] | port_out[2:0];
        return r;
    endfunction

    // results first: an item accepted at this edge cannot come out at it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            port_dir = PORT_DIR_RESET;
            port_out = PORT_OUT_RESET;
            exp_en   = 1'b0;
            iface_en = 1'b0;
            expected_decodes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_decodes.size() == 0) begin
                    report_mismatch("unexpected item", {12'h000, i_out_item.target_region},
                                    16'h0000);
                end else begin
                    want = expected_decodes.pop_front();
                    if (i_out_item.target_region !== want.target_region)
                        report_mismatch("target_region", {12'h000, i_out_item.target_region},
                                        {12'h000, want.target_region});
                    if (i_out_item.target_offset !== want.target_offset)
                        report_mismatch("target_offset", i_out_item.target_offset,
                                        want.target_offset);
                    if (i_out_item.port_read_data !== want.port_read_data)
                        report_mismatch("port_read_data", {8'h00, i_out_item.port_read_data},
                                        {8'h00, want.port_read_data});
                    if (i_out_item.dma_trigger !== want.dma_trigger)
                        report_mismatch("dma_trigger", {15'h0000, i_out_item.dma_trigger},
                                        {15'h0000, want.dma_trigger});
                    if (i_out_item.bank_mode !== want.bank_mode)
                        report_mismatch("bank_mode", {13'h0000, i_out_item.bank_mode},
                                        {13'h0000, want.bank_mode});
                end
                o_checked++;
            end
            // register writes on the apb port
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_cfg_index'(i_paddr[2]))
                    CFG_EXPANSION: exp_en = i_pwdata[0];
                    CFG_INTERFACE: iface_en = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                expected_decodes.push_back(decode_access(i_in_item));
        end
        o_pending <= expected_decodes.size();
    end

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the bank decoder: directed accesses over most regions in
// bank modes 7, 3 and 0, then random bus accesses under each enable setting, with
// random idle cycles on both channels, a long output hold-off and a drain
// pause. The checker beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import hcbd_pkg::*;

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_item  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_item;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // shared pacing controls, driven with nonblocking assignments
    logic                  quiet     = 1'b0;
    int                    hold_reqs = 0;

    int                    n_mismatch;
    int                    n_pending;
    int                    n_checked;
    int                    n_sent = 0;

    always #5 i_clk = ~i_clk;

    home_computer_bank_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    hcbd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_mismatches (n_mismatch),
        .o_pending    (n_pending),
        .o_checked    (n_checked)
    );

    function automatic t_in_item bus_access(input logic wr, input logic [15:0] addr,
                                            input logic [7:0] data, input logic [1:0] vb,
                                            input logic tape);
        t_in_item a;
        a.req_type    = wr;
        a.address     = addr;
        a.write_data  = data;
        a.video_bank  = vb;
        a.tape_button = tape;
        return a;
    endfunction

    // random access, weighted toward the port, i/o, rom and video bank pages
    function automatic t_in_item random_access();
        t_in_item a;
        int       sel;
        a.req_type    = 1'($urandom_range(0, 1));
        a.write_data  = 8'($urandom);
        a.video_bank  = 2'($urandom);
        a.tape_button = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (sel < 12) a.address = 16'($urandom_range(0, 1));
        else if (sel < 37) a.address = {4'hd, 12'($urandom)};
        else if (sel < 47) a.address = {3'b101, 13'($urandom)};
        else if (sel < 57) a.address = {3'b111, 13'($urandom)};
        else if (sel < 60) a.address = DMA_ADDR;
        else if (sel < 67) a.address = {a.video_bank,
                                        ($urandom_range(0, 1) ? SUB_PAGE_39 : SUB_PAGE_3F),
                                        8'($urandom)};
        else if (sel < 70) a.address = {8'h00, 8'($urandom)};
        else a.address = 16'($urandom);
        // keep the low direction bits driven half the time so every mode shows up
        if (a.address == 16'h0000 && $urandom_range(0, 1)) a.write_data[2:0] = 3'b111;
        return a;
    endfunction

    // offer one item, hold it until taken, then maybe idle
    task automatic offer_access(input t_in_item a);
        in_valid <= 1'b1;
        in_item  <= a;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        n_sent++;
        if (!quiet && $urandom_range(0, 99) < 38) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
    endtask

    // stop offering and wait until every predicted decode has come back
    task automatic wait_results_done();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (n_pending != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    // apb write: setup cycle, then access cycle until pready
    task automatic write_cfg(input t_cfg_index idx, input logic val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {31'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: random stalls, quiet stretches and a counted hold-off
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= !quiet && ($urandom_range(0, 99) < 38);
            end
        end
    end

    // run limit
    initial begin
        #2000000;
        $display("home_computer_bank_decoder test failed");
        $finish;
    end

    initial begin : stimulus
        t_in_item directed[$];
        logic     exp_set[5];
        logic     iface_set[5];
        exp_set   = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        iface_set = '{1'b0, 1'b0, 1'b1, 1'b1, 1'b0};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset state is mode 7: port reads, all i/o units, roms
        directed.push_back(bus_access(1'b0, 16'h0000, 8'h00, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'h0001, 8'h00, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'h0001, 8'h00, 2'd0, 1'b1));
        directed.push_back(bus_access(1'b0, 16'ha000, 8'h00, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'hd000, 8'h00, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'hd7ff, 8'h00, 2'd1, 1'b0));
        directed.push_back(bus_access(1'b0, 16'hdbff, 8'h00, 2'd2, 1'b0));
        directed.push_back(bus_access(1'b0, 16'hdc0d, 8'h00, 2'd3, 1'b0));
        directed.push_back(bus_access(1'b0, 16'hdd00, 8'h00, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'hde00, 8'h00, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'hdf05, 8'h00, 2'd0, 1'b0));
        // i/o write wins over the video bank
        directed.push_back(bus_access(1'b1, 16'hd020, 8'h0e, 2'd3, 1'b0));
        // all port bits outputs, then mode 3 with character rom
        directed.push_back(bus_access(1'b1, 16'h0000, 8'hff, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b1, 16'h0001, 8'h33, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'hd000, 8'h00, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'he000, 8'h00, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'hbfff, 8'h00, 2'd0, 1'b0));
        // mode 0: all ram
        directed.push_back(bus_access(1'b1, 16'h0001, 8'h30, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'hffff, 8'h00, 2'd0, 1'b0));
        // video bank writes, special pages inside the bank
        directed.push_back(bus_access(1'b1, 16'hb912, 8'haa, 2'd2, 1'b0));
        directed.push_back(bus_access(1'b1, 16'hbf00, 8'h55, 2'd2, 1'b0));
        directed.push_back(bus_access(1'b1, 16'h8123, 8'h01, 2'd2, 1'b0));
        // page ff write is plain ram, no dma with expansion off
        directed.push_back(bus_access(1'b1, 16'hff00, 8'h00, 2'd3, 1'b0));
        directed.push_back(bus_access(1'b1, 16'h0002, 8'hff, 2'd0, 1'b0));
        directed.push_back(bus_access(1'b0, 16'h0000, 8'h00, 2'd0, 1'b1));
        foreach (directed[i]) offer_access(directed[i]);

        // random phases, one per enable setting
        for (int ph = 0; ph < 5; ph++) begin
            wait_results_done();
            write_cfg(CFG_EXPANSION, exp_set[ph]);
            write_cfg(CFG_INTERFACE, iface_set[ph]);
            for (int k = 0; k < 280; k++) begin
                if (ph == 1 && k == 100) hold_reqs <= hold_reqs + 1;
                if (ph == 2 && k == 140) wait_results_done();
                if (ph == 3) quiet <= (k < 120);
                offer_access(random_access());
            end
        end

        wait_results_done();
        $display("sent %0d bus accesses over 5 enable settings, %0d decodes checked",
                 n_sent, n_checked);
        $display("included an output hold-off, a drain pause and a stretch without idling");
        if (n_mismatch == 0 && n_pending == 0) begin
            $display("home_computer_bank_decoder test passed");
        end else begin
            $display("home_computer_bank_decoder test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* home_computer_bank_decoder.f */
design/hcbd_pkg.sv
design/hcbd_cfg.sv
design/hcbd_core.sv
design/hcbd_out_buf.sv
design/home_computer_bank_decoder.sv
design/hcbd_checker.sv
tb/hcbd_checker.sv
tb/tb.sv
